// ===== src/lru_key_value_cache_core_assert.svh =====
// assertion helpers for the rtl
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// same-cycle implication
`define LKV_ASSERT_IMP(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LKV_ASSERT_NXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lkv_pkg.sv =====
package lkv_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int CAP_W       = 5;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef struct packed {
		logic capture;
		logic touch;
		logic insert;
	} lkv_ctrl_t;

endpackage

// ===== src/lkv_cell.sv =====
module lkv_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkv_pkg::lkv_ctrl_t          ctrl,
	input  logic                        cell_valid,
	input  logic [lkv_pkg::KEY_W-1:0]   lookup_key,
	input  logic [lkv_pkg::KEY_W-1:0]   prev_key,
	input  logic [lkv_pkg::VALUE_W-1:0] prev_value,
	input  logic                        seen_in,
	output logic                        seen_out,
	output logic                        match_q,
	output logic [lkv_pkg::KEY_W-1:0]   key_q,
	output logic [lkv_pkg::VALUE_W-1:0] value_q
);

	logic shift_en;

	// a hit at or below this cell moves this cell one place down
	assign seen_out = match_q | seen_in;
	assign shift_en = (ctrl.touch & seen_out) | ctrl.insert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.capture) begin
			match_q <= cell_valid && (key_q == lookup_key);
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

endmodule

// ===== src/lru_key_value_cache_core.sv =====
// lru key/value cache, entries kept in a chain of cells ordered by recency
// a request is compared as it is accepted, then updates the cells; a get also loads the output register
// a new request is taken only after the last one's update, which a get holds while a result waits unread
// a get result may wait in the output register while the next request is taken
// reset: asynchronous, empties the cache and sets capacity to ENTRIES
module lru_key_value_cache_core #(
	parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_data,   // capacity
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [63:0]               s_tdata,    // key [31:0], value [63:32]
	input  logic [0:0]                s_tuser,    // mode
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,    // read_value
	output logic [0:0]                m_tuser     // hit
);

	localparam int KW    = lkv_pkg::KEY_W;
	localparam int VW    = lkv_pkg::VALUE_W;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CW    = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

	logic [OCC_W-1:0]         occ_q;
	logic [CW-1:0]            cap_q;
	logic                     busy_q;
	logic                     req_mode_s1;
	logic [KW-1:0]            req_key_s1;
	logic [VW-1:0]            req_value_s1;
	logic                     out_valid_q;
	logic                     out_hit_q;
	logic [VW-1:0]            out_value_q;

	logic                     accept;
	logic                     exec;
	logic                     is_put;
	logic                     hit;
	logic [VW-1:0]            hit_value;
	logic [CW-1:0]            occ_x;
	logic [CW-1:0]            cap_x;
	logic [OCC_W-1:0]         occ_next;
	lkv_pkg::lkv_ctrl_t       ctrl;

	logic [ENTRIES-1:0]       match_v;
	logic [ENTRIES-1:0]       valid_v;
	logic [ENTRIES:0]         seen_v;
	logic [KW-1:0]            key_v   [ENTRIES];
	logic [VW-1:0]            value_v [ENTRIES];
	logic [KW-1:0]            head_key;
	logic [VW-1:0]            head_value;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign is_put    = (req_mode_s1 == lkv_pkg::MODE_PUT);
	assign exec      = busy_q && (is_put || !out_valid_q || m_tready);
	assign hit       = |match_v;

	always_comb begin
		hit_value = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			hit_value = hit_value | (value_v[j] & {VW{match_v[j]}});
		end
	end

	assign ctrl.capture = accept;
	assign ctrl.touch   = exec && hit && (is_put || !out_valid_q || m_tready);
	assign ctrl.insert  = exec && is_put && !hit;

	// new head entry: the request on a put, the hit entry on a get
	assign head_key   = req_key_s1;
	assign head_value = is_put ? req_value_s1 : hit_value;

	// entries past capacity-1 fall off the end when a new key comes in
	assign occ_x    = CW'(occ_q);
	assign cap_x    = cap_q;
	assign occ_next = (occ_x >= cap_x) ? OCC_W'(cap_x) : OCC_W'(occ_x + CW'(1));

	assign seen_v[ENTRIES] = 1'b0;

	for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
		assign valid_v[j] = (occ_q > OCC_W'(j));

		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.cell_valid (valid_v[j]),
			.lookup_key (s_tdata[KW-1:0]),
			.prev_key   ((j == 0) ? head_key : key_v[(j == 0) ? 0 : j - 1]),
			.prev_value ((j == 0) ? head_value : value_v[(j == 0) ? 0 : j - 1]),
			.seen_in    (seen_v[j+1]),
			.seen_out   (seen_v[j]),
			.match_q    (match_v[j]),
			.key_q      (key_v[j]),
			.value_q    (value_v[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(ENTRIES);
		end else if (cfg_valid && cfg_ready) begin
			if (CW'(cfg_data) > CW'(ENTRIES)) begin
				cap_q <= CW'(ENTRIES);
			end else if (cfg_data == '0) begin
				cap_q <= CW'(1);
			end else begin
				cap_q <= CW'(cfg_data);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (ctrl.insert) begin
				occ_q <= occ_next;
			end
			if (exec && !is_put) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_mode_s1  <= s_tuser[0];
			req_key_s1   <= s_tdata[KW-1:0];
			req_value_s1 <= s_tdata[KW+VW-1:KW];
		end
		if (exec && !is_put) begin
			out_hit_q   <= hit;
			out_value_q <= hit_value;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_value_q;
	assign m_tuser[0] = out_hit_q;

`include "lru_key_value_cache_core_assert.svh"

	`LKV_ASSERT_IMP(a_match_unique, arst_n, busy_q, $onehot0(match_v), "multiple key matches")
	`LKV_ASSERT_IMP(a_occ_range, arst_n, 1'b1, CW'(occ_q) <= CW'(ENTRIES), "occupancy overflow")
	`LKV_ASSERT_IMP(a_cap_range, arst_n, 1'b1,
		(cap_q != '0) && (cap_q <= CW'(ENTRIES)), "capacity out of range")
	`LKV_ASSERT_NXT(a_insert_fills, arst_n, ctrl.insert, occ_q != '0, "insert left cache empty")
	`LKV_ASSERT_NXT(a_get_stall, arst_n, busy_q && !is_put && out_valid_q && !m_tready,
		busy_q, "get executed over a pending result")

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import lkv_pkg::*;

	localparam int ENT       = lkv_pkg::ENTRIES_DEF;
	localparam int POOL_N    = 24;
	localparam int PHASE_N   = 12;
	localparam int PHASE_LEN = 144;
	localparam int LIMIT     = 400000;

	typedef struct packed {
		logic              mode;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic              hit;
		logic [VALUE_W-1:0] rdata;
	} lookup_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CAP_W-1:0]    cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [63:0]         s_tdata   = '0;
	logic [0:0]          s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [31:0]         m_tdata;
	logic [0:0]          m_tuser;

	request_t pending_q[$];
	lookup_t  lookups_due[$];
	int queued_count   = 0;
	int accepted_count = 0;
	int errors         = 0;
	int cycles         = 0;
	int get_count      = 0;
	int put_count      = 0;
	int hit_count      = 0;
	int cfg_count      = 0;
	bit bursts_on      = 1'b1;
	int src_gap        = 0;
	int snk_gap        = 0;

	// shadow copy of the cache
	logic [KEY_W-1:0]   shadow_key [ENT];
	logic [VALUE_W-1:0] shadow_val [ENT];
	logic               shadow_vld [ENT];
	int                 shadow_rank [ENT];
	int                 shadow_occ = 0;
	int                 shadow_cap = ENT;

	logic [KEY_W-1:0] key_pool [POOL_N];
	int pool_n = 8;

	lru_key_value_cache_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int shadow_find(logic [KEY_W-1:0] k);
		for (int i = 0; i < ENT; i++)
			if (shadow_vld[i] && shadow_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void shadow_promote(int idx);
		int r;
		r = shadow_rank[idx];
		for (int j = 0; j < ENT; j++)
			if (shadow_vld[j] && shadow_rank[j] < r)
				shadow_rank[j]++;
		shadow_rank[idx] = 0;
	endfunction

	function automatic void shadow_drop_oldest();
		if (shadow_occ == 0)
			return;
		for (int j = 0; j < ENT; j++) begin
			if (shadow_vld[j] && shadow_rank[j] == shadow_occ - 1) begin
				shadow_vld[j]  = 1'b0;
				shadow_rank[j] = 0;
				shadow_occ--;
				return;
			end
		end
	endfunction

	function automatic void shadow_insert(logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
		int slot;
		slot = -1;
		while (shadow_occ >= shadow_cap && shadow_occ > 0)
			shadow_drop_oldest();
		for (int j = 0; j < ENT; j++) begin
			if (!shadow_vld[j]) begin
				if (slot < 0)
					slot = j;
			end else begin
				shadow_rank[j]++;
			end
		end
		if (slot < 0)
			return;
		shadow_key[slot]  = k;
		shadow_val[slot]  = v;
		shadow_vld[slot]  = 1'b1;
		shadow_rank[slot] = 0;
		shadow_occ++;
	endfunction

	// apply one request to the shadow cache, queue the expected result of a get
	function automatic void cache_access(logic mode, logic [KEY_W-1:0] k,
			logic [VALUE_W-1:0] v);
		int idx;
		lookup_t res;
		idx = shadow_find(k);
		if (mode == MODE_GET) begin
			get_count++;
			if (idx >= 0) begin
				shadow_promote(idx);
				res.hit   = 1'b1;
				res.rdata = shadow_val[idx];
			end else begin
				res.hit   = 1'b0;
				res.rdata = '0;
			end
			lookups_due.push_back(res);
		end else begin
			put_count++;
			if (idx >= 0) begin
				shadow_val[idx] = v;
				shadow_promote(idx);
			end else begin
				shadow_insert(k, v);
			end
		end
	endfunction

	function automatic void queue_request(logic mode, logic [KEY_W-1:0] k,
			logic [VALUE_W-1:0] v);
		request_t rq;
		rq.mode  = mode;
		rq.key   = k;
		rq.value = v;
		pending_q.push_back(rq);
		queued_count++;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				cache_access(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
				accepted_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					request_t rq;
					rq = pending_q.pop_front();
					s_tdata  <= {rq.value, rq.key};
					s_tuser  <= rq.mode;
					s_tvalid <= 1'b1;
					if (bursts_on && $urandom_range(0, 9) == 0)
						src_gap = $urandom_range(1, 16);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_mon
		lookup_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (lookups_due.size() == 0) begin
					$error("result with no lookup pending: hit %0d read_value %h",
						m_tuser[0], m_tdata);
					errors++;
				end else begin
					exp_r = lookups_due.pop_front();
					if (m_tuser[0] !== exp_r.hit) begin
						$error("hit: expected %0d, got %0d", exp_r.hit, m_tuser[0]);
						errors++;
					end
					if (m_tdata !== exp_r.rdata) begin
						$error("read_value: expected %h, got %h", exp_r.rdata, m_tdata);
						errors++;
					end
					if (m_tuser[0] === 1'b1)
						hit_count++;
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (bursts_on && $urandom_range(0, 11) == 0)
					snk_gap = $urandom_range(1, 16);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic drain();
		while (accepted_count != queued_count || lookups_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_cap = (int'(c) > ENT) ? ENT : ((c == '0) ? 1 : int'(c));
		cfg_count++;
	endtask

	task automatic random_phase(input int n);
		logic [KEY_W-1:0] k;
		for (int i = $urandom_range(2, 8); i > 0; i--)
			key_pool[$urandom_range(0, POOL_N - 1)] = $urandom();
		pool_n = shadow_cap + $urandom_range(1, 6);
		if (pool_n > POOL_N)
			pool_n = POOL_N;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 80)
				k = key_pool[$urandom_range(0, pool_n - 1)];
			else
				k = $urandom();
			queue_request(1'($urandom_range(0, 1)), k, $urandom());
		end
	endtask

	initial begin
		int cap_plan [PHASE_N];
		cap_plan = '{0, 31, 3, 16, 1, 17, 2, 7, 16, 5, 12, 16};
		for (int i = 0; i < ENT; i++) begin
			shadow_vld[i]  = 1'b0;
			shadow_rank[i] = 0;
		end
		for (int i = 0; i < POOL_N; i++)
			key_pool[i] = $urandom();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h7FFF_FFFF;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty cache, extreme keys and values, update of a present key
		queue_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
		queue_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_request(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_request(MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
		queue_request(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
		queue_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_request(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
		queue_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
		queue_request(MODE_GET, 32'h0000_0001, 32'hFFFF_FFFF);
		queue_request(MODE_PUT, 32'h0000_0005, 32'hA5A5_A5A5);
		queue_request(MODE_GET, 32'h0000_0005, 32'h0000_0000);
		drain();

		// capacity dropped below occupancy: next new key clears all but itself
		write_capacity(CAP_W'(cap_plan[0]));
		queue_request(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		queue_request(MODE_PUT, 32'h0000_0011, 32'h5A5A_5A5A);
		queue_request(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		queue_request(MODE_GET, 32'h0000_0011, 32'h0000_0000);
		random_phase(PHASE_LEN);
		drain();

		for (int p = 1; p < PHASE_N; p++) begin
			write_capacity(CAP_W'(cap_plan[p]));
			if (p == PHASE_N - 1)
				bursts_on = 1'b0;
			else
				bursts_on = ($urandom_range(0, 3) != 0);
			random_phase(PHASE_LEN);
			drain();
		end

		repeat (6) @(posedge clk);
		$display("covered %0d gets (%0d hits), %0d puts, %0d capacity writes",
			get_count, hit_count, put_count, cfg_count);
		if (errors == 0 && lookups_due.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
